FILE: rtl/lru_page_cache_lookup_core_defines.svh
// Assertion macros used by the page cache lookup back end.
`ifndef LRU_PAGE_CACHE_LOOKUP_CORE_DEFINES_SVH
`define LRU_PAGE_CACHE_LOOKUP_CORE_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define LPC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define LPC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define LPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lpc_pkg.sv
// Types and constants for the page cache lookup block.
package lpc_pkg;

    localparam int TABLE_W     = 4;
    localparam int KIND_W      = 2;
    localparam int PAGE_W      = 24;
    localparam int SLOT_W      = 4;
    localparam int CAP_W       = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int RES_W       = 36;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request queue between front and back end
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // request as held in the queue, table index in the low bits
    typedef struct packed {
        logic [PAGE_W-1:0]  page_number;
        logic [KIND_W-1:0]  page_kind;
        logic [TABLE_W-1:0] table_index;
    } lpc_req_t;

    // result word, hit in bit 0
    typedef struct packed {
        logic [PAGE_W-1:0]  evicted_page;
        logic [KIND_W-1:0]  evicted_kind;
        logic [TABLE_W-1:0] evicted_table;
        logic               evicted;
        logic [SLOT_W-1:0]  slot;
        logic               hit;
    } lpc_result_t;

    typedef enum logic [0:0] {
        BK_LOOKUP,
        BK_UPDATE
    } lpc_back_state_t;

endpackage

FILE: rtl/lpc_front.sv
// Front end: request intake, key masking and a two-entry request queue.
module lpc_front
    import lpc_pkg::*;
#(
    parameter int PAGE_ID_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  q_valid,
    input  logic                  q_ready,
    output lpc_req_t              q_req
);

    localparam logic [PAGE_W-1:0] PAGE_MASK = (PAGE_ID_BITS >= PAGE_W) ? {PAGE_W{1'b1}} :
        PAGE_W'((PAGE_W'(1) << PAGE_ID_BITS) - PAGE_W'(1));

    lpc_req_t           q_data_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    lpc_req_t           in_req;
    logic               push;
    logic               pop;

    // unpack the request and drop page bits above the configured id width
    always_comb
    begin
        in_req = lpc_req_t'(s_axis_tdata[RES_W-7:0]);
        in_req.page_number = in_req.page_number & PAGE_MASK;
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_req         = q_data_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

FILE: rtl/lpc_back.sv
// Back end: tag store, recency ranks, replacement and result register.
`include "lru_page_cache_lookup_core_defines.svh"

module lpc_back
    import lpc_pkg::*;
#(
    parameter int ENTRIES      = 16,
    parameter int PAGE_ID_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  lpc_req_t               q_req,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int KPW  = (PAGE_ID_BITS < PAGE_W) ? PAGE_ID_BITS : PAGE_W;
    localparam int KW   = TABLE_W + KIND_W + KPW;
    localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;
    localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

    lpc_back_state_t    st_reg, st_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [OW-1:0]      occupancy_reg, occupancy_next;
    logic [KW-1:0]      keys_reg  [ENTRIES];
    logic [IW-1:0]      ranks_reg [ENTRIES];
    logic [IW-1:0]      ranks_next [ENTRIES];

    logic [KW-1:0]      key_reg;
    logic               hit_reg;
    logic               evict_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [IW-1:0]      victim_idx_reg;
    logic [IW-1:0]      free_idx_reg;

    logic               out_valid_reg, out_valid_next;
    lpc_result_t        out_data_reg;

    logic [KW-1:0]      head_key;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_oh;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      victim_idx;
    logic [IW-1:0]      free_idx;
    logic [IW-1:0]      occ_m1;
    logic [CMPW-1:0]    eff_cap;
    logic               evict_now;
    logic [IW-1:0]      hit_rank;
    logic [IW-1:0]      slot_sel;
    logic [KW-1:0]      ev_key;
    lpc_result_t        result;

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_data_reg};

    // lookup step: tag compare, victim and free slot search on the queue head
    always_comb
    begin
        head_key = {q_req.table_index, q_req.page_kind, q_req.page_number[KPW-1:0]};
        occ_m1   = IW'(occupancy_reg - OW'(1));
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i]  = valid_reg[i] && (keys_reg[i] == head_key);
            victim_vec[i] = valid_reg[i] && (ranks_reg[i] == occ_m1);
        end
        free_vec = ~valid_reg;
        free_oh  = free_vec & (~free_vec + 1'b1);
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_idx    = hit_idx    | (match_vec[i]  ? IW'(i) : '0);
            victim_idx = victim_idx | (victim_vec[i] ? IW'(i) : '0);
            free_idx   = free_idx   | (free_oh[i]    ? IW'(i) : '0);
        end
        // capacity zero acts as one, above the entry count as the entry count
        eff_cap = CMPW'(cap_reg);
        if (eff_cap == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (eff_cap > ENTRIES_C)
        begin
            eff_cap = ENTRIES_C;
        end
        evict_now = (CMPW'(occupancy_reg) >= eff_cap);
    end

    // update step: rank aging, fill or replacement, result
    always_comb
    begin
        hit_rank = ranks_reg[hit_idx_reg];
        ev_key   = keys_reg[victim_idx_reg];
        if (hit_reg)
        begin
            slot_sel = hit_idx_reg;
        end
        else if (evict_reg)
        begin
            slot_sel = victim_idx_reg;
        end
        else
        begin
            slot_sel = free_idx_reg;
        end

        valid_next     = valid_reg;
        occupancy_next = occupancy_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            ranks_next[i] = ranks_reg[i];
        end

        if (st_reg == BK_UPDATE)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && (!hit_reg || (ranks_reg[i] < hit_rank)))
                begin
                    ranks_next[i] = ranks_reg[i] + 1'b1;
                end
            end
            ranks_next[slot_sel] = '0;
            valid_next[slot_sel] = 1'b1;
            if (!hit_reg && !evict_reg)
            begin
                occupancy_next = occupancy_reg + 1'b1;
            end
        end

        result.hit           = hit_reg;
        result.slot          = SLOT_W'(slot_sel);
        result.evicted       = evict_reg;
        result.evicted_table = evict_reg ? ev_key[KW-1 -: TABLE_W] : '0;
        result.evicted_kind  = evict_reg ? ev_key[KPW +: KIND_W] : '0;
        result.evicted_page  = evict_reg ? PAGE_W'(ev_key[KPW-1:0]) : '0;
    end

    // sequencer: take a request only when the result register will be free
    always_comb
    begin
        st_next        = st_reg;
        q_ready        = 1'b0;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (st_reg)
            BK_LOOKUP:
            begin
                if (q_valid && (!out_valid_reg || m_axis_tready))
                begin
                    q_ready = 1'b1;
                    st_next = BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                out_valid_next = 1'b1;
                st_next        = BK_LOOKUP;
            end
            default:
            begin
                st_next = BK_LOOKUP;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_LOOKUP;
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            occupancy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            valid_reg     <= valid_next;
            occupancy_reg <= occupancy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // payload: lookup results, tags, ranks, result word
    always_ff @(posedge clk)
    begin
        if (q_ready)
        begin
            key_reg        <= head_key;
            hit_reg        <= |match_vec;
            evict_reg      <= !(|match_vec) && evict_now;
            hit_idx_reg    <= hit_idx;
            victim_idx_reg <= victim_idx;
            free_idx_reg   <= free_idx;
        end
        if ((st_reg == BK_UPDATE) && !hit_reg)
        begin
            keys_reg[slot_sel] <= key_reg;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            ranks_reg[i] <= ranks_next[i];
        end
        if (st_reg == BK_UPDATE)
        begin
            out_data_reg <= result;
        end
    end

    `LPC_ASSERT_ALWAYS(a_occ_count, $countones(valid_reg) == occupancy_reg, "occupancy mismatch")
    `LPC_ASSERT_IMPL(a_tag_unique, (st_reg == BK_LOOKUP) && q_valid, $onehot0(match_vec), "dup tag")
    `LPC_ASSERT_IMPL(a_victim_found, (st_reg == BK_LOOKUP) && q_valid && evict_now, $onehot(victim_vec), "no unique LRU victim")
    `LPC_ASSERT_IMPL(a_out_free, st_reg == BK_UPDATE, !out_valid_reg, "result register busy")
    `LPC_ASSERT_NEXT(a_hit_occ, (st_reg == BK_UPDATE) && hit_reg, occupancy_reg == $past(occupancy_reg), "hit changed occupancy")

endmodule

FILE: rtl/lru_page_cache_lookup_core.sv
// Top level of the fully associative LRU page cache lookup block.
//
// Requests arrive on s_axis: tdata carries table_index, page_kind and
// page_number. Each request yields exactly one result on m_axis: hit, the
// slot now holding the page, and on an eviction the key that was dropped.
// The capacity register is written on the cfg channel (always ready); the
// user must write it only while the block is idle, which the block does not
// enforce. Entries beyond it are evicted least recent first. The back end
// runs a lookup step that registers the tag compare and an update step that
// loads the result register in turn, and takes a request only in lookup.
// A two-entry request queue keeps s_axis taking requests while a result
// waits on a stalled m_axis; once the queue is full s_axis_tready drops.
// Results stay in the output register until m_axis_tready takes them.
// Reset empties the cache (all entries invalid, occupancy zero), clears the
// queue and sets the capacity to 16. No clearing pass is needed.
module lru_page_cache_lookup_core
    import lpc_pkg::*;
#(
    parameter int ENTRIES      = 16,
    parameter int PAGE_ID_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] table_index, [5:4] page_kind, [29:6] page_number, [31:30] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] hit, [4:1] slot, [5] evicted, [9:6] evicted_table,
    // [11:10] evicted_kind, [35:12] evicted_page, [39:36] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic     q_valid;
    logic     q_ready;
    lpc_req_t q_req;

    // request intake and queue
    lpc_front #(
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_req         (q_req)
    );

    // cache store, replacement and results
    lpc_back #(
        .ENTRIES      (ENTRIES),
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_req         (q_req),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: test/tb.sv
// Self-checking testbench for the LRU page cache lookup block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpc_pkg::*;

    localparam int LINES          = 16;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS     = 40;

    typedef enum logic [1:0] {
        STEP_LOOKUP,
        STEP_SET_CAPACITY,
        STEP_DRAIN
    } stim_op_t;

    typedef struct {
        stim_op_t          op;
        lpc_req_t          req;
        logic [CAP_W-1:0]  capacity;
        bit                no_gap;
    } stim_step_t;

    // DUT connections
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // stimulus and scoreboard
    stim_step_t  page_requests[$];
    lpc_result_t expected_lookups[$];
    int          quiet_cycles = 0;
    int          error_count  = 0;
    int          lookup_count = 0;
    int          hit_count    = 0;
    int          evict_count  = 0;
    int          cfg_writes   = 0;
    int          cycle_count  = 0;
    int          idle_cycles  = 0;

    // predictor state
    bit               line_valid[LINES];
    lpc_req_t         line_key[LINES];
    int               line_rank[LINES];
    int               line_count     = 0;
    logic [CAP_W-1:0] cache_capacity = CAP_RESET;

    lru_page_cache_lookup_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predict one lookup and update the cache model
    function automatic lpc_result_t lookup_page(lpc_req_t req);
        lpc_result_t res;
        int          slot_no;
        int          hit_rank;
        int          limit;
        int          oldest;
        bit          found;
        bit          placed;
        res     = '0;
        slot_no = 0;
        found   = 1'b0;
        placed  = 1'b0;
        for (int i = 0; i < LINES; i++)
            if (!found && line_valid[i] && line_key[i] == req)
            begin
                slot_no = i;
                found   = 1'b1;
            end
        if (found)
        begin
            // entries more recent than the hit age by one
            hit_rank = line_rank[slot_no];
            for (int i = 0; i < LINES; i++)
                if (line_valid[i] && line_rank[i] < hit_rank)
                    line_rank[i]++;
            line_rank[slot_no] = 0;
        end
        else
        begin
            // zero acts as one, anything above the line count as full size
            limit = (cache_capacity == 0) ? 1 :
                    (cache_capacity > LINES) ? LINES : int'(cache_capacity);
            if (line_count >= limit)
            begin
                oldest = -1;
                for (int i = 0; i < LINES; i++)
                    if (line_valid[i] && (oldest < 0 || line_rank[i] > line_rank[oldest]))
                        oldest = i;
                if (oldest >= 0)
                begin
                    res.evicted       = 1'b1;
                    res.evicted_table = line_key[oldest].table_index;
                    res.evicted_kind  = line_key[oldest].page_kind;
                    res.evicted_page  = line_key[oldest].page_number;
                    line_valid[oldest] = 1'b0;
                    line_count--;
                    slot_no = oldest;
                    placed  = 1'b1;
                end
            end
            // otherwise the lowest free line
            for (int i = 0; i < LINES; i++)
                if (!placed && !line_valid[i])
                begin
                    slot_no = i;
                    placed  = 1'b1;
                end
            if (placed)
            begin
                for (int i = 0; i < LINES; i++)
                    if (line_valid[i])
                        line_rank[i]++;
                line_valid[slot_no] = 1'b1;
                line_key[slot_no]   = req;
                line_rank[slot_no]  = 0;
                line_count++;
            end
        end
        res.hit  = found;
        res.slot = SLOT_W'(slot_no);
        return res;
    endfunction

    // One line per mismatch, printing capped, all counted
    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH lookup %0d %0s: got 0x%0h expected 0x%0h at %0t",
                     lookup_count - expected_lookups.size(), field, got, want, $realtime);
    endtask

    task automatic add_lookup(int tbl, int kind, int page, bit no_gap = 1'b0);
        stim_step_t st;
        st.op                  = STEP_LOOKUP;
        st.req.table_index     = TABLE_W'(tbl);
        st.req.page_kind       = KIND_W'(kind);
        st.req.page_number     = PAGE_W'(page);
        st.capacity            = '0;
        st.no_gap              = no_gap;
        page_requests.push_back(st);
    endtask

    task automatic add_key_lookup(lpc_req_t req, bit no_gap);
        add_lookup(req.table_index, req.page_kind, req.page_number, no_gap);
    endtask

    task automatic add_drain();
        stim_step_t st;
        st.op       = STEP_DRAIN;
        st.req      = '0;
        st.capacity = '0;
        st.no_gap   = 1'b0;
        page_requests.push_back(st);
    endtask

    // Capacity is only changed once the block has gone quiet
    task automatic add_capacity(int cap);
        stim_step_t st;
        add_drain();
        st.op       = STEP_SET_CAPACITY;
        st.req      = '0;
        st.capacity = CAP_W'(cap);
        st.no_gap   = 1'b0;
        page_requests.push_back(st);
    endtask

    function automatic lpc_req_t random_page_key();
        lpc_req_t k;
        k.table_index = TABLE_W'($urandom_range(15));
        k.page_kind   = KIND_W'($urandom_range(3));
        case ($urandom_range(9))
            0:       k.page_number = '0;
            1:       k.page_number = '1;
            default: k.page_number = PAGE_W'($urandom);
        endcase
        return k;
    endfunction

    // Request side: feeds lookups and capacity writes from the pending queue
    always @(posedge clk)
    begin
        stim_step_t nxt;
        logic       nv_s;
        logic       nv_c;
        if (rst_n && !(s_axis_tvalid && !s_axis_tready) && !(cfg_valid && !cfg_ready))
        begin
            nv_s = 1'b0;
            nv_c = 1'b0;
            if (page_requests.size() != 0)
            begin
                nxt = page_requests[0];
                case (nxt.op)
                    STEP_LOOKUP:
                        if (nxt.no_gap || $urandom_range(99) >= 33)
                        begin
                            nv_s = 1'b1;
                            s_axis_tdata <= IN_TDATA_W'(nxt.req);
                            void'(page_requests.pop_front());
                        end
                    STEP_SET_CAPACITY:
                    begin
                        nv_c = 1'b1;
                        cfg_data <= nxt.capacity;
                        void'(page_requests.pop_front());
                    end
                    STEP_DRAIN:
                        if (!s_axis_tvalid && !cfg_valid && expected_lookups.size() == 0)
                        begin
                            if (quiet_cycles >= DRAIN_CYCLES)
                            begin
                                quiet_cycles = 0;
                                void'(page_requests.pop_front());
                            end
                            else
                                quiet_cycles++;
                        end
                        else
                            quiet_cycles = 0;
                    default: void'(page_requests.pop_front());
                endcase
            end
            s_axis_tvalid <= nv_s;
            cfg_valid     <= nv_c;
        end
    end

    // Result side: predicts on accepted requests, checks accepted results,
    // drives the result backpressure and runs the watchdog
    always @(posedge clk)
    begin
        lpc_result_t got;
        lpc_result_t want;
        if (rst_n)
        begin
            cycle_count++;
            idle_cycles++;
            if (cfg_valid && cfg_ready)
            begin
                cache_capacity = cfg_data;
                cfg_writes++;
                idle_cycles = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = lookup_page(lpc_req_t'(s_axis_tdata[$bits(lpc_req_t)-1:0]));
                expected_lookups.push_back(want);
                lookup_count++;
                hit_count   += want.hit;
                evict_count += want.evicted;
                idle_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                got = lpc_result_t'(m_axis_tdata[RES_W-1:0]);
                if (expected_lookups.size() == 0)
                    report_mismatch("unexpected result", got[31:0], '0);
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("hit", got.hit, want.hit);
                    if (got.slot !== want.slot)
                        report_mismatch("slot", got.slot, want.slot);
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", got.evicted, want.evicted);
                    if (got.evicted_table !== want.evicted_table)
                        report_mismatch("evicted_table", got.evicted_table, want.evicted_table);
                    if (got.evicted_kind !== want.evicted_kind)
                        report_mismatch("evicted_kind", got.evicted_kind, want.evicted_kind);
                    if (got.evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
                end
                if (m_axis_tdata[OUT_TDATA_W-1:RES_W] !== '0)
                    report_mismatch("tdata padding", m_axis_tdata[OUT_TDATA_W-1:RES_W], '0);
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_lookups.size());
                $display("DONE: errors detected");
                $finish;
            end
            // ready held high through one stretch, random elsewhere
            m_axis_tready <= (cycle_count >= 1500 && cycle_count < 2300) ||
                             ($urandom_range(99) >= 33);
        end
    end

    // Stimulus plan and end of run
    initial
    begin
        int       caps[10];
        int       eff;
        lpc_req_t pool[$];
        lpc_req_t k;
        caps = '{16, 1, 31, 4, 0, 12, 16, 7, 20, 2};

        // directed: extremes, near-miss keys, hits, all page kinds
        add_lookup(0, 0, 0);
        add_lookup(15, 3, 24'hFFFFFF);
        add_lookup(0, 1, 0);
        add_lookup(0, 2, 0);
        add_lookup(8, 0, 24'h800000);
        add_lookup(0, 0, 0);
        add_lookup(15, 3, 24'hFFFFFF);
        add_lookup(15, 3, 24'hFFFFFE);
        add_lookup(7, 2, 24'h5A5A5A);
        // capacity dropped below occupancy: each miss evicts one
        add_capacity(2);
        add_lookup(1, 1, 1);
        add_lookup(2, 1, 2);
        add_lookup(1, 1, 1);
        add_lookup(0, 0, 0);
        // capacity zero behaves as one
        add_capacity(0);
        add_lookup(3, 0, 3);
        add_lookup(3, 0, 3);
        add_lookup(3, 1, 3);
        // capacity above the line count behaves as full size
        add_capacity(31);
        add_lookup(4, 0, 24'h000010);
        add_lookup(5, 1, 24'h0A0A0A);
        add_lookup(6, 2, 24'hF0F0F0);
        add_lookup(7, 3, 24'h123456);
        add_lookup(3, 1, 3);

        // random phases, each with its own capacity and a pool of hot keys
        foreach (caps[p])
        begin
            add_capacity(caps[p]);
            eff = (caps[p] == 0) ? 1 : (caps[p] > LINES) ? LINES : caps[p];
            pool.delete();
            repeat (eff + $urandom_range(3) + 1)
            begin
                if (pool.size() != 0 && $urandom_range(3) == 0)
                begin
                    // near neighbor of an existing key
                    k = pool[$urandom_range(pool.size() - 1)];
                    case ($urandom_range(2))
                        0: k.page_number[$urandom_range(PAGE_W - 1)] ^= 1'b1;
                        1: k.page_kind = ~k.page_kind;
                        default: k.table_index[$urandom_range(TABLE_W - 1)] ^= 1'b1;
                    endcase
                end
                else
                    k = random_page_key();
                pool.push_back(k);
            end
            for (int n = 0; n < 103; n++)
            begin
                // sender holds off until all results are back
                if ((p == 2 || p == 6) && n == 50)
                    add_drain();
                if ($urandom_range(99) < 80)
                    k = pool[$urandom_range(pool.size() - 1)];
                else
                    k = random_page_key();
                add_key_lookup(k, p == 5);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (page_requests.size() != 0 || s_axis_tvalid || cfg_valid ||
               expected_lookups.size() != 0);
        repeat (8) @(posedge clk);

        $display("Covered %0d lookups: %0d hits, %0d evictions, %0d capacity writes",
                 lookup_count, hit_count, evict_count, cfg_writes);
        $display("Capacities swept include zero, one, full size and out-of-range values");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
